// ===== sv/rmms_pkg.sv =====
package rmms_pkg;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_MERGE = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STRAT_LT = 3'd1,
    STRAT_LE = 3'd2,
    STRAT_EQ = 3'd3,
    STRAT_GE = 3'd4,
    STRAT_GT = 3'd5
  } strat_t;

  typedef enum logic {
    KIND_INT32 = 1'b0,
    KIND_WIDE  = 1'b1
  } key_kind_t;

  // Word index of the key kind register on the configuration port
  localparam logic REG_KEY_KIND = 1'b0;

  localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } key_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] value_hi;
    logic [63:0] value_lo;
    logic [63:0] other_max_hi;
    logic [63:0] other_max_lo;
    logic [2:0]  strategy;
  } item_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

  // Narrow a raw key to the active kind: low word only for int keys,
  // upper bytes beyond the wide key size cleared otherwise.
  function automatic key_t key_norm(key_kind_t kind, logic [63:0] hi, logic [63:0] lo,
                                    logic [63:0] hi_mask);
    key_t k;
    if (kind == KIND_INT32) begin
      k.hi = 64'd0;
      k.lo = {32'd0, lo[31:0]};
    end else begin
      k.hi = hi & hi_mask;
      k.lo = lo;
    end
    return k;
  endfunction

  // a < b under the active kind
  function automatic logic key_lt(key_kind_t kind, key_t a, key_t b);
    logic lt;
    if (kind == KIND_INT32) begin
      lt = (a.lo[31:0] ^ SIGN_FLIP) < (b.lo[31:0] ^ SIGN_FLIP);
    end else begin
      lt = (a.hi < b.hi) || ((a.hi == b.hi) && (a.lo < b.lo));
    end
    return lt;
  endfunction

endpackage

// ===== sv/rmms_in_if.sv =====
interface rmms_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] value_hi;
  logic [63:0] value_lo;
  logic [63:0] other_max_hi;
  logic [63:0] other_max_lo;
  logic [2:0]  strategy;

  modport source (
    output valid, command, value_hi, value_lo, other_max_hi, other_max_lo, strategy,
    input  ready
  );
  modport sink (
    input  valid, command, value_hi, value_lo, other_max_hi, other_max_lo, strategy,
    output ready
  );
endinterface

// ===== sv/rmms_out_if.sv =====
interface rmms_out_if;
  logic        valid;
  logic        ready;
  logic        flag;
  logic [63:0] min_hi;
  logic [63:0] min_lo;
  logic [63:0] max_hi;
  logic [63:0] max_lo;
  logic        is_empty;

  modport source (
    output valid, flag, min_hi, min_lo, max_hi, max_lo, is_empty,
    input  ready
  );
  modport sink (
    input  valid, flag, min_hi, min_lo, max_hi, max_lo, is_empty,
    output ready
  );
endinterface

// ===== sv/range_min_max_summary_top.sv =====
// A word accepted into the input register passes the bound compares and update on its way
// to the result register. Throughput: one word per cycle while the sink does not stall;
// the stored bounds feed back, so each word sees the bounds left by the word before it.
// Reset (synchronous, rst_n low): bounds cleared to zero, summary marked empty,
// key kind set to signed 32-bit, both pipeline registers emptied.
module range_min_max_summary_top
  import rmms_pkg::*;
#(
  parameter int WIDE_KEY_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  rmms_in_if.sink     in_ch,
  rmms_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  key_kind_t  key_kind;
  stage_ctl_t stage_ctl;
  item_t      stage_item;
  logic       advance;

  rmms_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .key_kind (key_kind)
  );

  rmms_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .ctl     (stage_ctl),
    .item    (stage_item)
  );

  rmms_core #(
    .WIDE_KEY_BYTES (WIDE_KEY_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_kind   (key_kind),
    .item_valid (stage_ctl.valid),
    .item       (stage_item),
    .advance    (advance),
    .out_ch     (out_ch)
  );

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> stage_ctl.valid)
    else $error("accepted word not held in input register");

  a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stage_ctl.valid && !stage_ctl.advance |=> stage_ctl.valid && $stable(stage_item))
    else $error("stalled input word lost or changed");

  a_empty_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_empty |-> !out_ch.flag)
    else $error("flag raised on empty summary");

  a_empty_bounds_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_empty |->
      out_ch.min_hi == 64'd0 && out_ch.min_lo == 64'd0 &&
      out_ch.max_hi == 64'd0 && out_ch.max_lo == 64'd0)
    else $error("empty summary shows non-zero bounds");

endmodule

// ===== sv/rmms_cfg.sv =====
module rmms_cfg
  import rmms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output key_kind_t   key_kind
);

  key_kind_t key_kind_r;
  logic      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_KEY_KIND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_kind_r <= KIND_INT32;
    end else if (wr_en) begin
      key_kind_r <= key_kind_t'(pwdata[0]);
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_KEY_KIND) begin
      prdata = {31'd0, key_kind_r};
    end
  end

  assign key_kind = key_kind_r;

endmodule

// ===== sv/rmms_in_stage.sv =====
module rmms_in_stage
  import rmms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  rmms_in_if.sink    in_ch,
  input  logic       advance,
  output stage_ctl_t ctl,
  output item_t      item
);

  logic  valid_r;
  item_t item_r;
  logic  take;

  // accept while the register is free or its word moves on this cycle
  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.command      <= in_ch.command;
      item_r.value_hi     <= in_ch.value_hi;
      item_r.value_lo     <= in_ch.value_lo;
      item_r.other_max_hi <= in_ch.other_max_hi;
      item_r.other_max_lo <= in_ch.other_max_lo;
      item_r.strategy     <= in_ch.strategy;
    end
  end

  assign ctl.valid   = valid_r;
  assign ctl.advance = advance;
  assign item        = item_r;

endmodule

// ===== sv/rmms_core.sv =====
module rmms_core
  import rmms_pkg::*;
#(
  parameter int WIDE_KEY_BYTES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  key_kind_t key_kind,
  input  logic      item_valid,
  input  item_t     item,
  output logic      advance,
  rmms_out_if.source out_ch
);

  localparam int          HI_BITS = 8 * (WIDE_KEY_BYTES - 8);
  localparam logic [63:0] HI_MASK = (HI_BITS >= 64) ? {64{1'b1}} :
                                    ((64'd1 << HI_BITS) - 64'd1);

  key_t lo_bound_r, lo_bound_nxt;
  key_t hi_bound_r, hi_bound_nxt;
  logic empty_r, empty_nxt;
  logic flag_nxt;

  logic        out_valid_r;
  logic        flag_r;
  key_t        res_min_r;
  key_t        res_max_r;
  logic        res_empty_r;

  key_t   v, om, nm, mn, mx;
  cmd_t   cmd;
  strat_t strat;
  logic   v_lt_mn, mn_lt_v, mx_lt_nm, nm_lt_mx;
  logic   fire;

  assign advance = !out_valid_r || out_ch.ready;
  assign fire    = item_valid && advance;

  assign cmd   = cmd_t'(item.command);
  assign strat = strat_t'(item.strategy);

  always_comb begin
    v  = key_norm(key_kind, item.value_hi, item.value_lo, HI_MASK);
    om = key_norm(key_kind, item.other_max_hi, item.other_max_lo, HI_MASK);
    mn = key_norm(key_kind, lo_bound_r.hi, lo_bound_r.lo, HI_MASK);
    mx = key_norm(key_kind, hi_bound_r.hi, hi_bound_r.lo, HI_MASK);
    nm = (cmd == CMD_MERGE) ? om : v;
    v_lt_mn  = key_lt(key_kind, v, mn);
    mn_lt_v  = key_lt(key_kind, mn, v);
    mx_lt_nm = key_lt(key_kind, mx, nm);
    nm_lt_mx = key_lt(key_kind, nm, mx);
  end

  always_comb begin
    lo_bound_nxt = lo_bound_r;
    hi_bound_nxt = hi_bound_r;
    empty_nxt    = empty_r;
    flag_nxt     = 1'b0;
    case (cmd) inside
      CMD_ADD, CMD_MERGE: begin
        if (empty_r) begin
          lo_bound_nxt = v;
          hi_bound_nxt = nm;
          empty_nxt    = 1'b0;
          flag_nxt     = 1'b1;
        end else begin
          if (v_lt_mn) begin
            lo_bound_nxt = v;
            flag_nxt     = 1'b1;
          end
          if (mx_lt_nm) begin
            hi_bound_nxt = nm;
            flag_nxt     = 1'b1;
          end
        end
      end
      CMD_QUERY: begin
        if (!empty_r) begin
          case (strat)
            STRAT_LT: flag_nxt = mn_lt_v;
            STRAT_LE: flag_nxt = !v_lt_mn;
            STRAT_EQ: flag_nxt = !v_lt_mn && !mx_lt_nm;
            STRAT_GE: flag_nxt = !mx_lt_nm;
            STRAT_GT: flag_nxt = nm_lt_mx;
            default:  flag_nxt = 1'b0;
          endcase
        end
      end
      default: begin
        lo_bound_nxt = '0;
        hi_bound_nxt = '0;
        empty_nxt    = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_bound_r <= '0;
      hi_bound_r <= '0;
      empty_r    <= 1'b1;
    end else if (fire) begin
      lo_bound_r <= lo_bound_nxt;
      hi_bound_r <= hi_bound_nxt;
      empty_r    <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid;
    end
  end

  // result word holds while the sink stalls
  always_ff @(posedge clk) begin
    if (fire) begin
      flag_r      <= flag_nxt;
      res_min_r   <= lo_bound_nxt;
      res_max_r   <= hi_bound_nxt;
      res_empty_r <= empty_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.flag     = flag_r;
  assign out_ch.min_hi   = res_min_r.hi;
  assign out_ch.min_lo   = res_min_r.lo;
  assign out_ch.max_hi   = res_max_r.hi;
  assign out_ch.max_lo   = res_max_r.lo;
  assign out_ch.is_empty = res_empty_r;

endmodule
